// File: hdl/double_ended_queue_top_defines.svh
// Assertion macros for the double-ended queue.
// Used by double_ended_queue_top.sv; the clock and reset names are taken from the includer.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by deq_ptr, double_ended_queue_top, the checker and the testbench.
package deq_pkg;

    // Field widths of the request and result items.
    localparam int unsigned MODE_W = 3;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CAP_W  = 7;

    // Stream bus widths, rounded up to whole bytes.
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 72;

    // Request operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_QUERY      = 3'd4
    } t_mode;

    // Status of the last request, held until the next one is taken.
    typedef struct packed {
        logic accepted;
        logic empty;
        logic full;
    } t_stat;

endpackage

// File: hdl/deq_ram.sv
// Ring store of the queue: one write port and two registered read ports.
// No dependencies; instantiated by double_ended_queue_top.
module deq_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

// File: hdl/deq_ptr.sv
// Head, tail and count registers with the capacity register and update logic.
// Depends on deq_pkg; instantiated by double_ended_queue_top.
module deq_ptr #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [deq_pkg::CAP_W-1:0]    i_cfg_wr_data,
    input  logic                         i_go,
    input  logic [deq_pkg::MODE_W-1:0]   i_mode,
    output logic                         o_wr_en,
    output logic [$clog2(DEPTH)-1:0]     o_wr_addr,
    output logic [$clog2(DEPTH)-1:0]     o_front_addr,
    output logic [$clog2(DEPTH)-1:0]     o_rear_addr,
    output deq_pkg::t_stat               o_stat
);

    import deq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    t_stat            r_stat;

    logic [KW-1:0] w_cap_ext;
    logic [CW-1:0] w_eff_cap;
    logic [AW-1:0] w_head_prev;
    logic [AW-1:0] w_head_next;
    logic [AW-1:0] w_tail_prev;
    logic [AW-1:0] w_tail_next;
    logic          w_can_push;
    logic          w_can_pop;
    logic          w_ok;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;

    // Capacity above the store depth saturates to the depth.
    assign w_cap_ext = KW'(r_cap);
    assign w_eff_cap = (w_cap_ext > KW'(DEPTH)) ? CW'(DEPTH) : w_cap_ext[CW-1:0];

    // Ring neighbours of the head and tail indices.
    assign w_head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_prev = (r_tail == '0) ? AW'(DEPTH - 1) : r_tail - 1'b1;
    assign w_tail_next = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign w_can_push = r_count < w_eff_cap;
    assign w_can_pop  = r_count != '0;

    // Decode the request into index updates and a store write.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_ok      = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_tail;
        unique case (i_mode)
            MODE_PUSH_FRONT: begin
                if (w_can_push) begin
                    n_head    = w_head_prev;
                    n_count   = r_count + 1'b1;
                    w_ok      = 1'b1;
                    o_wr_en   = i_go;
                    o_wr_addr = w_head_prev;
                end
            end
            MODE_PUSH_BACK: begin
                if (w_can_push) begin
                    n_tail    = w_tail_next;
                    n_count   = r_count + 1'b1;
                    w_ok      = 1'b1;
                    o_wr_en   = i_go;
                    o_wr_addr = r_tail;
                end
            end
            MODE_POP_FRONT: begin
                if (w_can_pop) begin
                    n_head  = w_head_next;
                    n_count = r_count - 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (w_can_pop) begin
                    n_tail  = w_tail_prev;
                    n_count = r_count - 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_QUERY: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(64);
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Index and count registers, with the status of the request just applied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_stat  <= '0;
        end else if (i_go) begin
            r_head          <= n_head;
            r_tail          <= n_tail;
            r_count         <= n_count;
            r_stat.accepted <= w_ok;
            r_stat.empty    <= n_count == '0;
            r_stat.full     <= n_count == w_eff_cap;
        end
    end

    assign o_front_addr = r_head;
    assign o_rear_addr  = w_tail_prev;
    assign o_stat       = r_stat;

endmodule

// File: hdl/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit words held in a ring store. A request is handled
// in order by acceptance, in which the indices update and a push writes the store; the read
// of the front and rear entries from the synchronous store; and the load of the result
// register, which waits while the previous result is still pending and not taken.
// A finished result waits in its own register, so the next request is accepted while the
// previous result is still pending. Depends on deq_pkg, deq_ptr, deq_ram and the defines header.
module double_ended_queue_top #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Capacity limit register (7 bits, unsigned).
    input  logic                          i_cfg_wr_en,
    input  logic [deq_pkg::CAP_W-1:0]     i_cfg_wr_data,
    // Requests.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // From bit 0: mode[2:0], push_value[34:3], zero fill [39:35].
    input  logic [deq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Results.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // From bit 0: accepted[0], front_value[32:1], rear_value[64:33], values_valid[65],
    // is_empty[66], is_full[67], zero fill [71:68].
    output logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import deq_pkg::*;

    `include "double_ended_queue_top_defines.svh"

    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state              r_state;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_front;
    logic [WORD_W-1:0]   r_out_rear;
    t_stat               r_out_stat;

    logic                w_in_acc;
    logic                w_load;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_front_addr;
    logic [AW-1:0]       w_rear_addr;
    logic [WORD_W-1:0]   w_rd_front;
    logic [WORD_W-1:0]   w_rd_rear;
    t_stat               w_stat;

    assign s_axis_tready = r_state == S_IDLE;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_LOAD) && (!r_out_valid || m_axis_tready);

    // Index, count and capacity control.
    deq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_go          (w_in_acc),
        .i_mode        (s_axis_tdata[MODE_W-1:0]),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_front_addr  (w_front_addr),
        .o_rear_addr   (w_rear_addr),
        .o_stat        (w_stat)
    );

    // Entry store; the reads are issued once the indices have settled.
    deq_ram #(
        .DEPTH(DEPTH),
        .WIDTH(WORD_W)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (s_axis_tdata[MODE_W +: WORD_W]),
        .i_rd_en     (r_state == S_READ),
        .i_rd_addr_a (w_front_addr),
        .i_rd_addr_b (w_rear_addr),
        .o_rd_data_a (w_rd_front),
        .o_rd_data_b (w_rd_rear)
    );

    // Sequencer and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; an empty queue reports zero words.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_front <= w_stat.empty ? '0 : w_rd_front;
            r_out_rear  <= w_stat.empty ? '0 : w_rd_rear;
            r_out_stat  <= w_stat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_stat.full, r_out_stat.empty, !r_out_stat.empty,
                            r_out_rear, r_out_front, r_out_stat.accepted};

    // Only one request is in flight at a time.
    `DEQ_ASSERT_NXT(a_one_in_flight, w_in_acc, !s_axis_tready, "request accepted while busy")

    // A pending result is never overwritten by the next one.
    `DEQ_ASSERT_NXT(a_hold_load, (r_state == S_LOAD) && r_out_valid && !m_axis_tready,
                    r_state == S_LOAD, "result register overwritten while stalled")

    // A new result appears only after the store read has completed.
    `DEQ_ASSERT_IMP(a_valid_after_read, $rose(m_axis_tvalid), $past(r_state) == S_LOAD,
                    "result valid without a completed read")

endmodule

// File: test/double_ended_queue_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended queue: watches the request, result and configuration ports,
// predicts each result from its own copy of the queue state and compares field by field.
// Depends on deq_pkg for the field widths and operation codes.
module double_ended_queue_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [deq_pkg::CAP_W-1:0]      i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [deq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output int unsigned                    o_pending,
    output int unsigned                    o_mismatches
);

    import deq_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned IDX_W = $clog2(DEPTH);

    // Result fields in bus order: the last member sits in bit 0.
    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic              values_valid;
        logic [WORD_W-1:0] rear_value;
        logic [WORD_W-1:0] front_value;
        logic              accepted;
    } t_deq_outcome;

    // Shadow copy of the queue. The ring is a power of two deep, so the indices wrap by width.
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]  head_pos;
    logic [IDX_W-1:0]  tail_pos;
    logic [CAP_W-1:0]  occupancy;
    logic [CAP_W-1:0]  capacity;
    t_deq_outcome      awaited_outcomes [$];
    int unsigned       pending_count  = 0;
    int unsigned       mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic t_deq_outcome apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [WORD_W-1:0] word);
        t_deq_outcome     res;
        logic [CAP_W-1:0] room;
        logic [IDX_W-1:0] last_pos;
        // Capacities above the ring depth behave as the ring depth.
        room = (capacity > DEPTH) ? CAP_W'(DEPTH) : capacity;
        res  = '0;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (occupancy < room) begin
                    head_pos             = head_pos - 1'b1;
                    ring_words[head_pos] = word;
                    occupancy            = occupancy + 1'b1;
                    res.accepted         = 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (occupancy < room) begin
                    ring_words[tail_pos] = word;
                    tail_pos             = tail_pos + 1'b1;
                    occupancy            = occupancy + 1'b1;
                    res.accepted         = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (occupancy != 0) begin
                    head_pos     = head_pos + 1'b1;
                    occupancy    = occupancy - 1'b1;
                    res.accepted = 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (occupancy != 0) begin
                    tail_pos     = tail_pos - 1'b1;
                    occupancy    = occupancy - 1'b1;
                    res.accepted = 1'b1;
                end
            end
            MODE_QUERY: res.accepted = 1'b1;
            // Unused codes leave the queue alone and are not accepted.
            default: res.accepted = 1'b0;
        endcase
        // Front and rear are only meaningful, and only read, while the queue holds something.
        last_pos         = tail_pos - 1'b1;
        res.values_valid = (occupancy != 0);
        res.is_empty     = (occupancy == 0);
        res.is_full      = (occupancy == room);
        if (occupancy != 0) begin
            res.front_value = ring_words[head_pos];
            res.rear_value  = ring_words[last_pos];
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Sample all channels at the rising edge, as the block does.
    always @(posedge i_clk) begin : watch_channels
        t_deq_outcome got;
        t_deq_outcome want;
        if (!i_rst_n) begin
            head_pos  = '0;
            tail_pos  = '0;
            occupancy = '0;
            capacity  = CAP_W'(64);
            awaited_outcomes.delete();
        end else begin
            // Results first: a result can never belong to a request taken at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_deq_outcome)-1:0];
                if (awaited_outcomes.size() == 0) begin
                    $error("result %0h arrived with no request outstanding", got);
                    mismatch_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("front_value", want.front_value, got.front_value);
                    compare_field("rear_value", want.rear_value, got.rear_value);
                    compare_field("values_valid", want.values_valid, got.values_valid);
                    compare_field("is_empty", want.is_empty, got.is_empty);
                    compare_field("is_full", want.is_full, got.is_full);
                end
            end
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_outcomes.push_back(apply_request(s_axis_tdata[MODE_W-1:0],
                                                         s_axis_tdata[MODE_W +: WORD_W]));
            end
        end
        pending_count = awaited_outcomes.size();
    end

endmodule

// File: test/double_ended_queue_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: drives requests, capacity writes and result
// back-pressure, and gives the verdict. Depends on deq_pkg, the block and its checker.
module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int unsigned          pending;
    int unsigned          mismatches;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    logic                 hold_pending  = 1'b0;
    logic [CAP_W-1:0]     current_cap   = CAP_W'(64);
    int unsigned          cycle_count   = 0;

    double_ended_queue_top #(
        .DEPTH(64)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    double_ended_queue_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
    initial begin : result_receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Extremes turn up often; otherwise any 32-bit word.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one request, with an occasional gap before it, and returns at the falling edge
    // after it is taken. Valid stays high so that back-to-back requests need no gap.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_axis_tdata  = {{(S_TDATA_W - MODE_W - WORD_W){1'b0}}, word, mode};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Capacity is only rewritten once every outstanding result has been delivered.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = cap;
        current_cap   = cap;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Random traffic made mostly of push runs and pop runs long enough to fill and drain the
    // queue, with single requests of any code mixed in. Ignored codes do not count.
    task automatic run_batch(input int unsigned items);
        int unsigned       done;
        int unsigned       span;
        int unsigned       burst;
        int unsigned       pick;
        logic [MODE_W-1:0] mode;
        span = ((current_cap > 64) ? 64 : current_cap) + 2;
        done = 0;
        while (done < items) begin
            pick  = $urandom_range(9, 0);
            burst = (pick < 8) ? $urandom_range(span, 1) : 1;
            repeat (burst) begin
                if (pick < 4) begin
                    mode = $urandom_range(1, 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                end else if (pick < 8) begin
                    mode = $urandom_range(1, 0) ? MODE_POP_BACK : MODE_POP_FRONT;
                end else begin
                    mode = MODE_W'($urandom_range(7, 0));
                end
                send_request(mode, random_word());
                if (mode <= MODE_QUERY) begin
                    done++;
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 15;
        recv_idle_pct <= 70;

        // Empty queue: query, refused pops, and an unused code.
        send_request(MODE_QUERY, random_word());
        send_request(MODE_POP_FRONT, random_word());
        send_request(MODE_POP_BACK, random_word());
        send_request(3'd5, random_word());
        // Extreme words at both ends, unused codes on a non-empty queue, then drain it.
        send_request(MODE_PUSH_FRONT, 32'h7fff_ffff);
        send_request(MODE_PUSH_BACK, 32'h8000_0000);
        send_request(MODE_PUSH_FRONT, 32'h0000_0000);
        send_request(MODE_PUSH_BACK, 32'hffff_ffff);
        send_request(3'd6, random_word());
        send_request(3'd7, random_word());
        send_request(MODE_POP_FRONT, random_word());
        send_request(MODE_POP_BACK, random_word());
        send_request(MODE_POP_BACK, random_word());
        send_request(MODE_POP_FRONT, random_word());

        // Zero capacity: pushes refused, an empty queue reads as full too.
        set_capacity(CAP_W'(0));
        send_request(MODE_PUSH_FRONT, random_word());
        send_request(MODE_PUSH_BACK, random_word());
        send_request(MODE_QUERY, random_word());

        // Fill a small queue, then lower the capacity beneath the count.
        set_capacity(CAP_W'(2));
        send_request(MODE_PUSH_BACK, random_word());
        send_request(MODE_PUSH_FRONT, random_word());
        send_request(MODE_PUSH_BACK, random_word());
        set_capacity(CAP_W'(1));
        send_request(MODE_PUSH_FRONT, random_word());
        send_request(MODE_QUERY, random_word());
        send_request(MODE_POP_BACK, random_word());
        send_request(MODE_POP_FRONT, random_word());

        // Largest register value saturates to the ring depth.
        set_capacity(CAP_W'(127));
        send_request(MODE_QUERY, random_word());
        run_batch(100);
        set_capacity(CAP_W'(3));
        run_batch(100);

        send_idle_pct = 70;
        recv_idle_pct <= 15;
        set_capacity(CAP_W'(1));
        run_batch(60);
        set_capacity(CAP_W'(0));
        run_batch(40);
        set_capacity(CAP_W'(65));
        run_batch(100);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_capacity(CAP_W'(5));
        run_batch(60);
        // Results held back for a long stretch while requests keep coming.
        set_capacity(CAP_W'(64));
        hold_pending <= 1'b1;
        run_batch(150);

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
